@@ hdl/bdl_pkg.sv @@
// ----------------------------------------------------------------------------
// bdl_pkg
// Shared types and constants for the bounded double-ended list.
// ----------------------------------------------------------------------------
package bdl_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int LNK_W      = $clog2(CAPACITY + 1);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam logic [LNK_W-1:0] NIL = LNK_W'(CAPACITY);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WALK,
    S_APPLY,
    S_LINK,
    S_PATCH,
    S_DONE
  } state_t;

  // one memory port request from the sequencer
  typedef struct packed {
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic                  wr_val_en;
    logic [DATA_WIDTH-1:0] wr_val;
    logic                  wr_next_en;
    logic [LNK_W-1:0]      wr_next;
    logic                  wr_prev_en;
    logic [LNK_W-1:0]      wr_prev;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] val;
    logic [LNK_W-1:0]      next;
    logic [LNK_W-1:0]      prev;
  } node_t;

endpackage

@@ hdl/bdl_node_mem.sv @@
// ----------------------------------------------------------------------------
// bdl_node_mem
// Node storage: value and links, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module bdl_node_mem (
  input  logic               clk,
  input  bdl_pkg::mem_req_t  req,
  output bdl_pkg::node_t     rd_node
);

  logic [bdl_pkg::DATA_WIDTH-1:0] val_mem  [bdl_pkg::CAPACITY];
  logic [bdl_pkg::LNK_W-1:0]      next_mem [bdl_pkg::CAPACITY];
  logic [bdl_pkg::LNK_W-1:0]      prev_mem [bdl_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en && req.wr_val_en)  val_mem[req.wr_addr]  <= req.wr_val;
    if (req.wr_en && req.wr_next_en) next_mem[req.wr_addr] <= req.wr_next;
    if (req.wr_en && req.wr_prev_en) prev_mem[req.wr_addr] <= req.wr_prev;
    if (req.rd_en) begin
      rd_node.val  <= val_mem[req.rd_addr];
      rd_node.next <= next_mem[req.rd_addr];
      rd_node.prev <= prev_mem[req.rd_addr];
    end
  end

endmodule

@@ hdl/bdl_free_pick.sv @@
// ----------------------------------------------------------------------------
// bdl_free_pick
// Free-node map with lowest-free-node selection, registered.
// ----------------------------------------------------------------------------
module bdl_free_pick (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic                        give,
  input  logic [bdl_pkg::IDX_W-1:0]   give_idx,
  output logic [bdl_pkg::IDX_W-1:0]   pick_r
);

  logic [bdl_pkg::CAPACITY-1:0] free_r, free_nxt;
  logic [bdl_pkg::IDX_W-1:0]    pick_nxt;

  always_comb begin
    free_nxt = free_r;
    if (take) free_nxt[pick_r] = 1'b0;
    if (give) free_nxt[give_idx] = 1'b1;
  end

  // priority encode from the top so the lowest free index wins
  always_comb begin
    pick_nxt = '0;
    for (int i = bdl_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (free_nxt[i]) pick_nxt = bdl_pkg::IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
      pick_r <= '0;
    end else begin
      free_r <= free_nxt;
      pick_r <= pick_nxt;
    end
  end

endmodule

@@ hdl/bounded_double_ended_list.sv @@
// ----------------------------------------------------------------------------
// bounded_double_ended_list
// Ordered list of up to CAPACITY words held as linked nodes in one memory.
// ----------------------------------------------------------------------------
// Channel  | Ports                                  | Transfer
// input    | start, busy, in_op/position/data_in    | start && !busy
// result   | out_valid, out_success/status/...      | out_valid, one cycle
//
// Push and pop: read, apply, link fix-up and report states, then the
// strobe; busy through those states.
// Insert after position p: the link walk steps p nodes through the single
// memory read port, one node per cycle, then apply, link fix-up, a patch
// of the successor's back link unless inserting after the tail, and report.
// Rejected requests go from read straight to report. Reset clears the
// free map, head, tail and count; node memory needs no clearing.
// The receiver cannot stall; a new transfer may be taken in the strobe cycle.
module bounded_double_ended_list (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [5:0]  in_position,
  input  logic [63:0] in_data_in,
  output logic        out_valid,
  output logic        out_success,
  output logic [1:0]  out_status,
  output logic [63:0] out_data_out,
  output logic [6:0]  out_element_count
);

  localparam int IW = bdl_pkg::IDX_W;
  localparam int LW = bdl_pkg::LNK_W;
  localparam int CW = bdl_pkg::CNT_W;
  localparam int DW = bdl_pkg::DATA_WIDTH;

  bdl_pkg::state_t   state_r, state_nxt;
  bdl_pkg::mem_req_t req;
  bdl_pkg::node_t    rd_node;

  logic [2:0]    op_r;
  logic [5:0]    pos_r;
  logic [DW-1:0] din_r;
  logic [LW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r;
  logic [LW-1:0] cur_r;   // node under the walk
  logic [5:0]    step_r;  // walk steps left
  logic [LW-1:0] nb_r;    // neighbor to patch after the new node is written
  logic [LW-1:0] new_r;   // node taken by a push or insert
  logic          ok_r;
  logic [1:0]    st_r;
  logic [DW-1:0] dout_r;
  logic [IW-1:0] pick;
  logic          take, give;
  logic [IW-1:0] give_idx;
  logic          accept;
  logic          reject;
  logic [1:0]    rej_st;

  assign accept = start && !busy;
  assign busy   = (state_r != bdl_pkg::S_IDLE);

  bdl_node_mem u_mem (.clk(clk), .req(req), .rd_node(rd_node));

  bdl_free_pick u_free (
    .clk(clk), .rst_n(rst_n), .take(take), .give(give),
    .give_idx(give_idx), .pick_r(pick)
  );

  // screen the request against count and position
  always_comb begin
    reject = 1'b0;
    rej_st = bdl_pkg::ST_OK;
    unique case (op_r)
      bdl_pkg::OP_PUSH_FRONT, bdl_pkg::OP_PUSH_BACK: begin
        if (count_r == CW'(bdl_pkg::CAPACITY)) begin
          reject = 1'b1; rej_st = bdl_pkg::ST_FULL;
        end
      end
      bdl_pkg::OP_POP_FRONT, bdl_pkg::OP_POP_BACK: begin
        if (count_r == '0) begin
          reject = 1'b1; rej_st = bdl_pkg::ST_EMPTY;
        end
      end
      bdl_pkg::OP_INSERT: begin
        priority if (count_r == '0) begin
          reject = 1'b1; rej_st = bdl_pkg::ST_EMPTY;
        end else if (CW'(pos_r) >= count_r) begin
          reject = 1'b1; rej_st = bdl_pkg::ST_RANGE;
        end else if (count_r == CW'(bdl_pkg::CAPACITY)) begin
          reject = 1'b1; rej_st = bdl_pkg::ST_FULL;
        end
      end
      default: begin
        reject = 1'b1; rej_st = bdl_pkg::ST_RANGE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdl_pkg::S_IDLE:  if (accept) state_nxt = bdl_pkg::S_READ;
      bdl_pkg::S_READ: begin
        priority if (reject) state_nxt = bdl_pkg::S_DONE;
        else if (op_r == bdl_pkg::OP_INSERT) state_nxt = bdl_pkg::S_WALK;
        else state_nxt = bdl_pkg::S_APPLY;
      end
      bdl_pkg::S_WALK:  if (step_r == '0) state_nxt = bdl_pkg::S_APPLY;
      bdl_pkg::S_APPLY: state_nxt = bdl_pkg::S_LINK;
      bdl_pkg::S_LINK: begin
        // insert with a successor also patches the successor's back link
        if (op_r == bdl_pkg::OP_INSERT && nb_r != bdl_pkg::NIL)
          state_nxt = bdl_pkg::S_PATCH;
        else
          state_nxt = bdl_pkg::S_DONE;
      end
      bdl_pkg::S_PATCH: state_nxt = bdl_pkg::S_DONE;
      bdl_pkg::S_DONE:  state_nxt = bdl_pkg::S_IDLE;
      default:          state_nxt = bdl_pkg::S_IDLE;
    endcase
  end

  // memory requests and free-map updates
  always_comb begin
    req      = '0;
    take     = 1'b0;
    give     = 1'b0;
    give_idx = head_r[IW-1:0];
    unique case (state_r)
      bdl_pkg::S_READ: begin
        // fetch the node the operation pivots on; pushes need no read
        req.rd_en   = !reject && (op_r != bdl_pkg::OP_PUSH_FRONT) &&
                      (op_r != bdl_pkg::OP_PUSH_BACK);
        req.rd_addr = (op_r == bdl_pkg::OP_POP_BACK) ? tail_r[IW-1:0]
                                                     : head_r[IW-1:0];
      end
      bdl_pkg::S_WALK: begin
        // advance one link per cycle; read data is the node at cur_r
        req.rd_en   = (step_r != '0);
        req.rd_addr = rd_node.next[IW-1:0];
      end
      bdl_pkg::S_APPLY: begin
        unique case (op_r)
          bdl_pkg::OP_PUSH_FRONT, bdl_pkg::OP_PUSH_BACK: begin
            take = 1'b1;
            req.wr_en = 1'b1; req.wr_addr = pick;
            req.wr_val_en = 1'b1; req.wr_val = din_r;
            req.wr_next_en = 1'b1; req.wr_prev_en = 1'b1;
            req.wr_next = (op_r == bdl_pkg::OP_PUSH_FRONT) ? head_r : bdl_pkg::NIL;
            req.wr_prev = (op_r == bdl_pkg::OP_PUSH_BACK) ? tail_r : bdl_pkg::NIL;
            if (count_r == '0) begin
              req.wr_next = bdl_pkg::NIL; req.wr_prev = bdl_pkg::NIL;
            end
          end
          bdl_pkg::OP_POP_FRONT, bdl_pkg::OP_POP_BACK: begin
            // release the node leaving the list
            give     = 1'b1;
            give_idx = (op_r == bdl_pkg::OP_POP_FRONT) ? head_r[IW-1:0]
                                                       : tail_r[IW-1:0];
          end
          default: begin
            // new node sits between the walked node and its successor
            take = 1'b1;
            req.wr_en = 1'b1; req.wr_addr = pick;
            req.wr_val_en = 1'b1; req.wr_val = din_r;
            req.wr_next_en = 1'b1; req.wr_prev_en = 1'b1;
            req.wr_next = rd_node.next;
            req.wr_prev = cur_r;
          end
        endcase
      end
      bdl_pkg::S_LINK: begin
        // first link fix-up on the neighbor
        unique case (op_r)
          bdl_pkg::OP_PUSH_FRONT: begin
            req.wr_en = (count_r != CW'(1)); req.wr_addr = nb_r[IW-1:0];
            req.wr_prev_en = 1'b1; req.wr_prev = head_r;
          end
          bdl_pkg::OP_PUSH_BACK: begin
            req.wr_en = (count_r != CW'(1)); req.wr_addr = nb_r[IW-1:0];
            req.wr_next_en = 1'b1; req.wr_next = tail_r;
          end
          bdl_pkg::OP_POP_FRONT: begin
            req.wr_en = (count_r != '0); req.wr_addr = head_r[IW-1:0];
            req.wr_prev_en = 1'b1; req.wr_prev = bdl_pkg::NIL;
          end
          bdl_pkg::OP_POP_BACK: begin
            req.wr_en = (count_r != '0); req.wr_addr = tail_r[IW-1:0];
            req.wr_next_en = 1'b1; req.wr_next = bdl_pkg::NIL;
          end
          default: begin
            req.wr_en = 1'b1; req.wr_addr = cur_r[IW-1:0];
            req.wr_next_en = 1'b1; req.wr_next = new_r;
          end
        endcase
      end
      bdl_pkg::S_PATCH: begin
        // point the old successor back at the inserted node
        req.wr_en = 1'b1; req.wr_addr = nb_r[IW-1:0];
        req.wr_prev_en = 1'b1; req.wr_prev = new_r;
      end
      default: ;
    endcase
  end

  // list bookkeeping and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bdl_pkg::S_IDLE;
      head_r    <= bdl_pkg::NIL;
      tail_r    <= bdl_pkg::NIL;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == bdl_pkg::S_DONE);
      if (state_r == bdl_pkg::S_APPLY) begin
        unique case (op_r)
          bdl_pkg::OP_PUSH_FRONT: begin
            head_r <= LW'(pick);
            if (count_r == '0) tail_r <= LW'(pick);
            count_r <= count_r + CW'(1);
          end
          bdl_pkg::OP_PUSH_BACK: begin
            tail_r <= LW'(pick);
            if (count_r == '0) head_r <= LW'(pick);
            count_r <= count_r + CW'(1);
          end
          bdl_pkg::OP_POP_FRONT: begin
            if (count_r == CW'(1)) begin
              head_r <= bdl_pkg::NIL; tail_r <= bdl_pkg::NIL;
            end else head_r <= rd_node.next;
            count_r <= count_r - CW'(1);
          end
          bdl_pkg::OP_POP_BACK: begin
            if (count_r == CW'(1)) begin
              head_r <= bdl_pkg::NIL; tail_r <= bdl_pkg::NIL;
            end else tail_r <= rd_node.prev;
            count_r <= count_r - CW'(1);
          end
          default: begin
            if (rd_node.next == bdl_pkg::NIL) tail_r <= LW'(pick);
            count_r <= count_r + CW'(1);
          end
        endcase
      end
    end
  end

  // request capture, walk pointer and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      pos_r <= in_position;
      din_r <= in_data_in;
    end
    if (state_r == bdl_pkg::S_READ) begin
      ok_r   <= !reject;
      st_r   <= rej_st;
      dout_r <= '0;
      cur_r  <= head_r;
      step_r <= pos_r;
    end
    if (state_r == bdl_pkg::S_WALK && step_r != '0) begin
      cur_r  <= rd_node.next;
      step_r <= step_r - 6'd1;
    end
    if (state_r == bdl_pkg::S_APPLY) begin
      new_r <= LW'(pick);
      unique case (op_r)
        bdl_pkg::OP_PUSH_FRONT: nb_r <= head_r;
        bdl_pkg::OP_PUSH_BACK:  nb_r <= tail_r;
        bdl_pkg::OP_POP_FRONT, bdl_pkg::OP_POP_BACK: dout_r <= rd_node.val;
        default:                nb_r <= rd_node.next;
      endcase
    end
    if (state_r == bdl_pkg::S_DONE) begin
      out_success       <= ok_r;
      out_status        <= st_r;
      out_data_out      <= dout_r;
      out_element_count <= 7'(count_r);
    end
  end

  property p_busy_after_start;
    @(posedge clk) disable iff (!rst_n) accept |=> busy;
  endproperty
  a_busy_after_start: assert property (p_busy_after_start) else $error("busy low after start");

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= CW'(bdl_pkg::CAPACITY);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("count over capacity");

  property p_strobe_idle;
    @(posedge clk) disable iff (!rst_n) out_valid |-> !busy;
  endproperty
  a_strobe_idle: assert property (p_strobe_idle) else $error("strobe while busy");

endmodule

@@ tb/sv/bounded_double_ended_list_tb.sv @@
// ----------------------------------------------------------------------------
// bounded_double_ended_list_tb
// Self-checking bench: drives list requests, mirrors the list in a queue and
// compares every result strobe against the mirrored outcome.
// ----------------------------------------------------------------------------
module bounded_double_ended_list_tb;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  position;
    logic [63:0] data_in;
  } request_t;

  typedef struct packed {
    logic        success;
    logic [1:0]  status;
    logic [63:0] data_out;
    logic [6:0]  element_count;
  } answer_t;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_op = '0;
  logic [5:0]  in_position = '0;
  logic [63:0] in_data_in = '0;
  logic        out_valid;
  logic        out_success;
  logic [1:0]  out_status;
  logic [63:0] out_data_out;
  logic [6:0]  out_element_count;

  request_t    pending_reqs[$];
  answer_t     expected_answers[$];
  logic [63:0] list_words[$];   // mirror of the list, front at index 0
  int          send_idle_pct = 9;
  bit          hold_sends = 1'b0;
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          sent_count = 0;
  int          answer_count = 0;

  bounded_double_ended_list dut (.*);

  always #5 clk = ~clk;

  // Apply one request to the mirror and return the answer it should produce.
  function automatic answer_t apply_request(request_t r);
    answer_t a;
    a = '0;
    case (r.op)
      bdl_pkg::OP_PUSH_FRONT, bdl_pkg::OP_PUSH_BACK: begin
        if (list_words.size() >= bdl_pkg::CAPACITY) a.status = bdl_pkg::ST_FULL;
        else begin
          if (r.op == bdl_pkg::OP_PUSH_FRONT) list_words.push_front(r.data_in);
          else list_words.push_back(r.data_in);
          a.success = 1'b1;
          a.status = bdl_pkg::ST_OK;
        end
      end
      bdl_pkg::OP_POP_FRONT, bdl_pkg::OP_POP_BACK: begin
        if (list_words.size() == 0) a.status = bdl_pkg::ST_EMPTY;
        else begin
          a.data_out = (r.op == bdl_pkg::OP_POP_FRONT) ? list_words.pop_front()
                                                       : list_words.pop_back();
          a.success = 1'b1;
          a.status = bdl_pkg::ST_OK;
        end
      end
      bdl_pkg::OP_INSERT: begin
        if (list_words.size() == 0) a.status = bdl_pkg::ST_EMPTY;
        else if (r.position >= list_words.size()) a.status = bdl_pkg::ST_RANGE;
        else if (list_words.size() >= bdl_pkg::CAPACITY) a.status = bdl_pkg::ST_FULL;
        else begin
          list_words.insert(r.position + 1, r.data_in);
          a.success = 1'b1;
          a.status = bdl_pkg::ST_OK;
        end
      end
      default: a.status = bdl_pkg::ST_RANGE;
    endcase
    a.element_count = 7'(list_words.size());
    return a;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Queue one request at the back of the pending queue.
  task automatic queue_request(logic [2:0] op, logic [5:0] pos, logic [63:0] d);
    request_t r;
    r.op = op;
    r.position = pos;
    r.data_in = d;
    pending_reqs.push_back(r);
  endtask

  // Driver: transfer the next request when start && !busy; advance on accept.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_answers.push_back(apply_request(pending_reqs.pop_front()));
        sent_count <= sent_count + 1;
      end
      if (start && busy) begin
        // hold the current request until it is taken
      end else if (!hold_sends && pending_reqs.size() > 0
                   && $urandom_range(0, 99) >= send_idle_pct) begin
        request_t nx;
        nx = pending_reqs[0];
        start <= 1'b1;
        in_op <= nx.op;
        in_position <= nx.position;
        in_data_in <= nx.data_in;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobe with the oldest expected answer.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      answer_count <= answer_count + 1;
      if (expected_answers.size() == 0) begin
        $error("result strobe with no request outstanding");
        fail_count <= fail_count + 1;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (out_success !== e.success) begin
          $error("success: expected %0d got %0d", e.success, out_success);
          fail_count <= fail_count + 1;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d got %0d", e.status, out_status);
          fail_count <= fail_count + 1;
        end
        if (out_data_out !== e.data_out) begin
          $error("data_out: expected %h got %h", e.data_out, out_data_out);
          fail_count <= fail_count + 1;
        end
        if (out_element_count !== e.element_count) begin
          $error("element_count: expected %0d got %0d", e.element_count,
                 out_element_count);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  task automatic queue_random(int n, int fill_target);
    int est;
    est = list_words.size();
    repeat (n) begin
      int k;
      logic [2:0] op;
      k = $urandom_range(0, 99);
      if (k < 4) op = 3'($urandom_range(5, 7));        // unknown op noise
      else if (k < 50) op = (est < fill_target) ? 3'($urandom_range(0, 1))
                                                : 3'($urandom_range(2, 3));
      else if (k < 75) op = bdl_pkg::OP_INSERT;
      else op = 3'($urandom_range(0, 3));
      // positions mostly inside the list, sometimes beyond it
      queue_request(op, ($urandom_range(0, 9) == 0 || est == 0)
                        ? 6'($urandom()) : 6'($urandom_range(0, est - 1)),
                    rand_word());
      if (op <= bdl_pkg::OP_PUSH_BACK || op == bdl_pkg::OP_INSERT)
        est = (est < bdl_pkg::CAPACITY) ? est + 1 : est;
      else if (op <= bdl_pkg::OP_POP_BACK && est > 0) est = est - 1;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list pops and insert, pushes of extreme words, range
    // miss, insert at head and tail, unknown ops, pops of both ends.
    queue_request(bdl_pkg::OP_POP_FRONT, 6'd0, '0);
    queue_request(bdl_pkg::OP_POP_BACK, 6'd0, '0);
    queue_request(bdl_pkg::OP_INSERT, 6'd0, '1);
    queue_request(bdl_pkg::OP_PUSH_FRONT, 6'd63, '1);
    queue_request(bdl_pkg::OP_PUSH_BACK, 6'd0, '0);
    queue_request(bdl_pkg::OP_INSERT, 6'd0, 64'hA5A5_5A5A_F00F_0FF0);
    queue_request(bdl_pkg::OP_INSERT, 6'd2, 64'h5A5A_A5A5_0FF0_F00F);
    queue_request(bdl_pkg::OP_INSERT, 6'd4, 64'h1);
    queue_request(bdl_pkg::OP_INSERT, 6'd63, 64'h2);
    queue_request(3'd5, 6'd0, '1);
    queue_request(3'd7, 6'd63, '1);
    queue_request(bdl_pkg::OP_POP_FRONT, 6'd0, '0);
    queue_request(bdl_pkg::OP_POP_BACK, 6'd0, '0);
    queue_request(bdl_pkg::OP_POP_BACK, 6'd0, '0);
    queue_request(bdl_pkg::OP_POP_FRONT, 6'd0, '0);
    queue_request(bdl_pkg::OP_POP_FRONT, 6'd0, '0);
    wait_drained();

    // Fill to capacity, then probe full-list push and insert.
    repeat (bdl_pkg::CAPACITY)
      queue_request(bdl_pkg::OP_PUSH_BACK, 6'($urandom()), rand_word());
    queue_request(bdl_pkg::OP_PUSH_FRONT, 6'd0, '1);
    queue_request(bdl_pkg::OP_INSERT, 6'd62, '1);
    queue_request(bdl_pkg::OP_INSERT, 6'd63, '1);
    wait_drained();

    // Random phases: sender idles 9%, then 50%, then never; fill targets vary.
    queue_random(400, 40);
    wait_drained();
    hold_sends = 1'b1;        // pause with nothing outstanding
    repeat (20) @(posedge clk);
    hold_sends = 1'b0;
    send_idle_pct = 50;
    queue_random(400, 8);
    wait_drained();
    send_idle_pct = 0;
    queue_random(200, 64);
    queue_random(200, 20);
    wait_drained();

    repeat (bdl_pkg::CAPACITY + 10) @(posedge clk);
    $display("covered %0d requests and %0d results: empty, full, range, unknown op",
             sent_count, answer_count);
    if (fail_count == 0 && expected_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
